// ----- hdl/sed_pkg.sv -----
// ----------------------------------------------------------------------------
// sed_pkg
// Shared constants, types and table builders for the SPI serial EEPROM device.
// ----------------------------------------------------------------------------
package sed_pkg;

    // default geometry
    localparam int unsigned SED_MEM_BYTES  = 8192;
    localparam int unsigned SED_PAGE_BYTES = 32;

    // instruction codes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WRSR  = 8'h01;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_WRITE = 8'h02;

    // status register bits and masks
    localparam logic [7:0] ST_WEN    = 8'h02;
    localparam logic [7:0] ST_BUSY   = 8'h01;
    localparam logic [7:0] WRSR_MASK = 8'h8c;
    localparam logic [7:0] ERASED    = 8'hff;

    // byte position within a transaction
    localparam logic [1:0] POS_OPCODE = 2'd0;
    localparam logic [1:0] POS_ADDR_H = 2'd1;
    localparam logic [1:0] POS_ADDR_L = 2'd2;
    localparam logic [1:0] POS_DATA   = 2'd3;

    // memory access request of one word
    typedef struct packed {
        logic rd;
        logic wr;
    } mem_req_t;

    // result word as produced by the command decoder
    typedef struct packed {
        logic       use_mem;
        logic [7:0] data;
    } resp_t;

    // 256-entry residue table, 16 bits per entry
    typedef logic [255:0][15:0] mod_tab_t;

    // entry i holds (i * scale) mod modulus, reduced by shifted subtraction
    function automatic mod_tab_t mod_table(input int unsigned scale,
                                           input int unsigned modulus);
        mod_tab_t          tab;
        longint unsigned   v;
        longint unsigned   m;
        m = longint'(modulus);
        for (int i = 0; i < 256; i++) begin
            v = longint'(i) * longint'(scale);
            for (int k = 16; k >= 0; k--) begin
                if (v >= (m << k)) begin
                    v = v - (m << k);
                end
            end
            tab[i] = 16'(v);
        end
        return tab;
    endfunction

endpackage

// ----- hdl/sed_mem.sv -----
// ----------------------------------------------------------------------------
// sed_mem
// Cell array: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sed_mem
    import sed_pkg::*;
#(
    parameter int unsigned DEPTH = SED_MEM_BYTES,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/sed_ctrl.sv -----
// ----------------------------------------------------------------------------
// sed_ctrl
// Instruction decoder: transaction state, status register, address logic and
// the memory request for each word.
// ----------------------------------------------------------------------------
module sed_ctrl
    import sed_pkg::*;
#(
    parameter int unsigned MEM_BYTES  = SED_MEM_BYTES,
    parameter int unsigned PAGE_BYTES = SED_PAGE_BYTES,
    parameter int unsigned AW         = $clog2(MEM_BYTES)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          accept,
    input  logic          kind,
    input  logic [7:0]    mosi_byte,
    output mem_req_t      mem_req,
    output logic [AW-1:0] mem_addr,
    output resp_t         resp
);

    localparam int unsigned PW = $clog2(PAGE_BYTES);

    localparam mod_tab_t HI_MEM  = mod_table(256, MEM_BYTES);
    localparam mod_tab_t LO_MEM  = mod_table(1, MEM_BYTES);
    localparam mod_tab_t HI_PAGE = mod_table(256, PAGE_BYTES);
    localparam mod_tab_t LO_PAGE = mod_table(1, PAGE_BYTES);

    localparam logic [AW:0]   MEM_LIM  = (AW+1)'(MEM_BYTES);
    localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);
    localparam logic [PW:0]   PAGE_LIM = (PW+1)'(PAGE_BYTES);

    logic [7:0]    status_reg, status_next;
    logic [7:0]    opcode_reg, opcode_next;
    logic [1:0]    pos_reg, pos_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          wa_reg, wa_next;
    logic [7:0]    hi_reg, hi_next;

    logic [AW:0]   addr_sum;
    logic [AW-1:0] addr_load;
    logic [AW-1:0] addr_inc;
    logic [15:0]   addr_wide;
    logic [PW:0]   off_sum;
    logic [PW-1:0] page_off;
    logic [PW:0]   off_inc;
    logic [PW-1:0] off_next;
    logic [AW-1:0] page_base;
    logic [AW:0]   page_step;
    logic [AW-1:0] page_next;

    // start address from the two address bytes, reduced to the memory size
    assign addr_sum  = {1'b0, HI_MEM[hi_reg][AW-1:0]} + {1'b0, LO_MEM[mosi_byte][AW-1:0]};
    assign addr_load = (addr_sum >= MEM_LIM) ? AW'(addr_sum - MEM_LIM) : addr_sum[AW-1:0];

    // sequential read advance, wraps at the memory size
    assign addr_inc = (addr_reg == MEM_LAST) ? '0 : addr_reg + 1'b1;

    // offset inside the page of the current address
    assign addr_wide = 16'(addr_reg);
    assign off_sum   = {1'b0, HI_PAGE[addr_wide[15:8]][PW-1:0]}
                     + {1'b0, LO_PAGE[addr_wide[7:0]][PW-1:0]};
    assign page_off  = (off_sum >= PAGE_LIM) ? PW'(off_sum - PAGE_LIM) : off_sum[PW-1:0];

    // page write advance, wraps to the page start (also at a partial last page)
    assign off_inc   = {1'b0, page_off} + 1'b1;
    assign off_next  = (off_inc == PAGE_LIM) ? '0 : off_inc[PW-1:0];
    assign page_base = addr_reg - AW'(page_off);
    assign page_step = {1'b0, page_base} + (AW+1)'(off_next);
    assign page_next = (page_step >= MEM_LIM) ? page_base : page_step[AW-1:0];

    // decode of one word
    always_comb begin
        status_next = status_reg;
        opcode_next = opcode_reg;
        pos_next    = pos_reg;
        addr_next   = addr_reg;
        wa_next     = wa_reg;
        hi_next     = hi_reg;
        mem_req     = '0;
        mem_addr    = addr_reg;
        resp        = '{use_mem: 1'b0, data: mosi_byte};

        if (kind) begin
            opcode_next = '0;
            pos_next    = POS_OPCODE;
            addr_next   = '0;
            wa_next     = 1'b0;
            resp.data   = '0;
        end else begin
            if (opcode_reg == '0 && pos_reg == POS_OPCODE) begin
                opcode_next = mosi_byte;
            end
            case (opcode_next)
                OP_WREN: begin
                    status_next = status_reg | ST_WEN;
                end
                OP_WRDI: begin
                    status_next = status_reg & ~ST_WEN;
                end
                OP_RDSR: begin
                    if (pos_reg == POS_ADDR_H) begin
                        resp.data   = status_reg;
                        status_next = status_reg & ~ST_BUSY;
                    end
                end
                OP_WRSR: begin
                    status_next = mosi_byte & WRSR_MASK;
                end
                OP_READ: begin
                    case (pos_reg)
                        POS_ADDR_H: hi_next = mosi_byte;
                        POS_ADDR_L: addr_next = addr_load;
                        POS_DATA: begin
                            mem_req.rd   = 1'b1;
                            resp.use_mem = 1'b1;
                            addr_next    = addr_inc;
                        end
                        default: ;
                    endcase
                end
                OP_WRITE: begin
                    case (pos_reg)
                        POS_OPCODE: begin
                            wa_next     = (status_reg & ST_WEN) != '0;
                            status_next = (status_reg & ~ST_WEN) | ST_BUSY;
                        end
                        POS_ADDR_H: hi_next = mosi_byte;
                        POS_ADDR_L: addr_next = addr_load;
                        POS_DATA: begin
                            if (wa_reg) begin
                                mem_req.wr = 1'b1;
                                addr_next  = page_next;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (pos_reg != POS_DATA) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    // transaction state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg <= '0;
            opcode_reg <= '0;
            pos_reg    <= POS_OPCODE;
            addr_reg   <= '0;
            wa_reg     <= 1'b0;
        end else if (accept) begin
            status_reg <= status_next;
            opcode_reg <= opcode_next;
            pos_reg    <= pos_next;
            addr_reg   <= addr_next;
            wa_reg     <= wa_next;
        end
    end

    // high address byte, payload only
    always_ff @(posedge aclk) begin
        if (accept) begin
            hi_reg <= hi_next;
        end
    end

endmodule

// ----- hdl/spi_eeprom_device.sv -----
// ----------------------------------------------------------------------------
// spi_eeprom_device
// Device side of a 25xx-style SPI serial EEPROM, one word per SPI byte.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): each word is one full-duplex SPI byte
// (s_kind = 0, s_mosi_byte) or a chip-select release (s_kind = 1).
// Output channel (m_valid/m_ready): exactly one word per input word, the byte
// returned on MISO (m_miso_byte): read data, status, or an echo of the input;
// a release returns 0.
// m_valid rises in the cycle after input accept. Throughput is one word per
// cycle while the receiver keeps up and no sweep runs: the decoder and the cell
// array port handle one access per word, and the output register lets the next
// word enter while a result is taken. When the receiver stalls, the output
// register holds its word and s_ready drops until it is taken; the cell array
// read data is held as well. Reset clears the status register and the
// transaction state, then a sweep writes 0xFF to every cell, one cell per
// cycle; s_ready stays low during the sweep.
// ----------------------------------------------------------------------------
module spi_eeprom_device
    import sed_pkg::*;
#(
    parameter int unsigned MEM_BYTES  = SED_MEM_BYTES,
    parameter int unsigned PAGE_BYTES = SED_PAGE_BYTES
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_kind,
    input  logic [7:0] s_mosi_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_miso_byte
);

    localparam int unsigned AW = $clog2(MEM_BYTES);
    localparam logic [AW-1:0] MEM_LAST = AW'(MEM_BYTES - 1);

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    logic          in_fire;
    mem_req_t      mem_req;
    logic [AW-1:0] item_addr;
    resp_t         resp;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic          ram_rd_en;
    logic [7:0]    ram_rd_data;

    logic          out_valid_reg;
    logic          out_use_mem_reg;
    logic [7:0]    out_byte_reg;

    // input handshake
    assign s_ready = (state_reg == ST_RUN) && (!out_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;

    // clear sweep after reset
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        case (state_reg)
            ST_CLEAR: begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == MEM_LAST) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: ;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    sed_ctrl #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_BYTES (PAGE_BYTES),
        .AW         (AW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_fire),
        .kind      (s_kind),
        .mosi_byte (s_mosi_byte),
        .mem_req   (mem_req),
        .mem_addr  (item_addr),
        .resp      (resp)
    );

    // cell array port selection: sweep or word access
    assign ram_wr_en   = (state_reg == ST_CLEAR) || (in_fire && mem_req.wr);
    assign ram_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : item_addr;
    assign ram_wr_data = (state_reg == ST_CLEAR) ? ERASED : s_mosi_byte;
    assign ram_rd_en   = in_fire && mem_req.rd;

    sed_mem #(
        .DEPTH (MEM_BYTES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (item_addr),
        .rd_data (ram_rd_data)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_use_mem_reg <= resp.use_mem;
            out_byte_reg    <= resp.data;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_miso_byte = out_use_mem_reg ? ram_rd_data : out_byte_reg;

    // every accepted word shows up on the output the next cycle
    a_word_out: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid)
        else $error("accepted word did not reach the output register");

    // no result is presented while the cell array is being erased
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !m_valid)
        else $error("output valid during clear sweep");

    // a word never reads and writes the cell array at once
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_req.rd && mem_req.wr))
        else $error("read and write requested by the same word");

    // a read word takes its byte from the cell array
    a_read_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && mem_req.rd) |=> out_use_mem_reg)
        else $error("read word not routed from the cell array");

endmodule

// ----- test/spi_eeprom_device_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spi_eeprom_device_tb
// Drives SPI byte and chip-select release words into the EEPROM device and
// compares every returned MISO word against a cycle-free behavioral copy of
// the device kept in the bench. Covers the status instructions, page write
// wrap, read wrap, ignored instructions, random traffic with idling on both
// sides, a long output stall and a full-rate stretch at the end.
// ----------------------------------------------------------------------------
module spi_eeprom_device_tb;
    import sed_pkg::*;

    localparam int unsigned MEM_BYTES   = SED_MEM_BYTES;
    localparam int unsigned PAGE_BYTES  = SED_PAGE_BYTES;
    localparam int          CLK_PERIOD  = 10;
    localparam int          HOLD_CYCLES = 120;
    localparam int          CYCLE_LIMIT = 300000;
    localparam logic [7:0]  OP_NONE     = 8'h00;
    localparam logic [7:0]  BAD_OPCODE  = 8'hff;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic       s_kind      = 1'b0;
    logic [7:0] s_mosi_byte = 8'h00;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_miso_byte;

    // device image held by the bench
    logic [7:0]  ee_status;
    logic [7:0]  ee_opcode;
    logic [1:0]  ee_pos;
    logic [15:0] ee_addr;
    logic        ee_armed;
    logic [7:0]  ee_cells [MEM_BYTES];

    logic [7:0]  miso_expected [$];
    logic [7:0]  miso_want;
    int          err_count   = 0;
    int          words_sent  = 0;
    int          cycle_count = 0;
    logic        idle_on     = 1'b1;
    logic        hold_req    = 1'b0;

    spi_eeprom_device u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_mosi_byte (s_mosi_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_miso_byte (m_miso_byte)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // run time guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // advance the device image by one word, return the byte seen on miso
    function automatic logic [7:0] miso_for_word(input logic kind, input logic [7:0] mosi);
        logic [7:0]  miso;
        logic [1:0]  pos;
        int unsigned a;
        int unsigned base;
        int unsigned nxt;
        miso = mosi;
        pos  = ee_pos;
        // chip select release closes the transaction
        if (kind) begin
            ee_opcode = OP_NONE;
            ee_pos    = POS_OPCODE;
            ee_addr   = '0;
            ee_armed  = 1'b0;
            return 8'h00;
        end
        if (ee_opcode == OP_NONE && pos == POS_OPCODE) begin
            ee_opcode = mosi;
        end
        case (ee_opcode)
            OP_WREN: ee_status = ee_status | ST_WEN;
            OP_WRDI: ee_status = ee_status & ~ST_WEN;
            OP_RDSR: begin
                // status shows once, then busy clears
                if (pos == POS_ADDR_H) begin
                    miso      = ee_status;
                    ee_status = ee_status & ~ST_BUSY;
                end
            end
            OP_WRSR: ee_status = mosi & WRSR_MASK;
            OP_READ, OP_WRITE: begin
                if (ee_opcode == OP_WRITE && pos == POS_OPCODE) begin
                    ee_armed  = (ee_status & ST_WEN) != 0;
                    ee_status = (ee_status & ~ST_WEN) | ST_BUSY;
                end else if (pos == POS_ADDR_H) begin
                    ee_addr = {mosi, 8'h00};
                end else if (pos == POS_ADDR_L) begin
                    ee_addr = 16'((ee_addr | 16'(mosi)) % MEM_BYTES);
                end else if (pos == POS_DATA) begin
                    a = ee_addr % MEM_BYTES;
                    if (ee_opcode == OP_READ) begin
                        miso    = ee_cells[a];
                        ee_addr = 16'((a + 1) % MEM_BYTES);
                    end else if (ee_armed) begin
                        // store and step inside the page
                        base        = a - a % PAGE_BYTES;
                        nxt         = base + (a % PAGE_BYTES + 1) % PAGE_BYTES;
                        ee_cells[a] = mosi;
                        if (nxt >= MEM_BYTES) begin
                            nxt = base;
                        end
                        ee_addr = 16'(nxt);
                    end
                end
            end
            default: ;
        endcase
        if (pos != POS_DATA) begin
            ee_pos = pos + 2'd1;
        end
        return miso;
    endfunction

    // offer one word, hold it until taken, then log its expected reply
    task automatic send_word(input logic kind, input logic [7:0] mosi);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_mosi_byte <= mosi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        miso_expected.push_back(miso_for_word(kind, mosi));
        words_sent++;
    endtask

    // one transaction: the low n bytes of the vector, most significant first, then release
    task automatic xfer(input logic [63:0] bytes, input int n);
        for (int i = n - 1; i >= 0; i--) begin
            send_word(1'b0, bytes[8*i +: 8]);
        end
        send_word(1'b1, 8'($urandom));
    endtask

    // mostly well-formed transactions, with broken and open-ended ones mixed in
    task automatic random_transaction();
        logic [7:0]  op;
        logic [15:0] addr;
        int          len;
        case ($urandom_range(0, 15))
            0, 1:       op = OP_WREN;
            2:          op = OP_WRDI;
            3, 4:       op = OP_RDSR;
            5:          op = OP_WRSR;
            6, 7, 8, 9: op = OP_READ;
            10, 11, 12: op = OP_WRITE;
            13:         op = OP_NONE;
            default:    op = 8'($urandom);
        endcase
        // writes mostly get a fresh enable first
        if (op == OP_WRITE && $urandom_range(0, 3) != 0) begin
            xfer(64'(OP_WREN), 1);
        end
        // hot spots at both ends of the array so reads meet written data
        case ($urandom_range(0, 3))
            0:       addr = 16'($urandom_range(0, 127));
            1:       addr = 16'h1fc0 + 16'($urandom_range(0, 63));
            default: addr = 16'($urandom);
        endcase
        if (op == OP_READ || op == OP_WRITE) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(0, 1);
            end else if ($urandom_range(0, 4) == 0) begin
                len = 2 + $urandom_range(7, 40);
            end else begin
                len = 2 + $urandom_range(0, 6);
            end
        end else begin
            len = $urandom_range(0, 3);
        end
        send_word(1'b0, op);
        for (int i = 1; i <= len; i++) begin
            if (i == 1) begin
                send_word(1'b0, addr[15:8]);
            end else if (i == 2) begin
                send_word(1'b0, addr[7:0]);
            end else begin
                send_word(1'b0, 8'($urandom));
            end
        end
        // now and then chip select stays low into the next instruction
        if ($urandom_range(0, 15) != 0) begin
            send_word(1'b1, 8'($urandom));
        end
        // stray release with nothing open
        if ($urandom_range(0, 15) == 0) begin
            send_word(1'b1, 8'($urandom));
        end
    endtask

    task automatic test_status_ops();
        xfer(64'(OP_WREN), 1);
        xfer({OP_RDSR, 8'h00}, 2);
        xfer({OP_WRSR, 8'hff}, 2);
        xfer(64'(OP_WRDI), 1);
    endtask

    // write across the end of the last page, then read across the array end
    task automatic test_page_write_wrap();
        xfer(64'(OP_WREN), 1);
        xfer({OP_WRITE, 8'hff, 8'hff, 8'ha5, 8'h5a}, 5);
        xfer({OP_RDSR, 8'h00}, 2);
        xfer({OP_READ, 8'h1f, 8'hff, 8'h00, 8'h00}, 5);
    endtask

    task automatic test_ignored_opcodes();
        xfer({OP_NONE, OP_WREN}, 2);
        xfer(64'(BAD_OPCODE), 1);
    endtask

    task automatic test_random_traffic(input int n_words);
        int stop_at;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) begin
            random_transaction();
        end
    endtask

    // receiver holds off while words keep coming, input must back up
    task automatic test_output_stall();
        int stop_at;
        stop_at  = words_sent + 30;
        hold_req = 1'b1;
        while (words_sent < stop_at) begin
            random_transaction();
        end
        while (hold_req) @(posedge aclk);
    endtask

    task automatic test_full_rate(input int n_words);
        idle_on = 1'b0;
        test_random_traffic(n_words);
    endtask

    // receiver side: random stalls, plus one long hold on request
    initial begin : sink
        int stall;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall = $urandom_range(1, 11);
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // compare each returned word with the oldest expected one
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (miso_expected.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %02h", $time, m_miso_byte);
                err_count++;
            end else begin
                miso_want = miso_expected.pop_front();
                if (m_miso_byte !== miso_want) begin
                    $display("%0t: miso mismatch, expected %02h actual %02h",
                             $time, miso_want, m_miso_byte);
                    err_count++;
                end
            end
        end
    end

    initial begin
        ee_status = 8'h00;
        ee_opcode = OP_NONE;
        ee_pos    = POS_OPCODE;
        ee_addr   = '0;
        ee_armed  = 1'b0;
        for (int i = 0; i < MEM_BYTES; i++) begin
            ee_cells[i] = ERASED;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_status_ops();
        test_page_write_wrap();
        test_ignored_opcodes();
        test_random_traffic(480);
        test_output_stall();
        test_full_rate(80);

        // drain, then idle quietly before the verdict
        s_valid <= 1'b0;
        while (miso_expected.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/sed_pkg.sv
hdl/sed_mem.sv
hdl/sed_ctrl.sv
hdl/spi_eeprom_device.sv
test/spi_eeprom_device_tb.sv
